>>> sv/tpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths, vertex types and register codes for the plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;        // vertex minus plane point
  localparam int PROD_W    = DIFF_W + COORD_W;   // normal times difference
  localparam int DIST_W    = PROD_W + 2;         // sum of three products
  localparam int DEN_W     = DIST_W + 1;         // d_in - d_out, always positive
  localparam int MUL_W     = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W     = MUL_W - FRAC_BITS + 1;
  localparam int CFG_IDX_W = 3;

  typedef logic [2:0][COORD_W-1:0] vtx_t;   // [0]=x, [1]=y, [2]=z
  typedef logic [2:0][DIFF_W-1:0]  dvec_t;
  typedef logic signed [DIST_W-1:0] dist_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PX = 3'd0,
    CFG_PY = 3'd1,
    CFG_PZ = 3'd2,
    CFG_NX = 3'd3,
    CFG_NY = 3'd4,
    CFG_NZ = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] NIN_NONE  = 2'd0;
  localparam logic [1:0] NIN_ONE   = 2'd1;
  localparam logic [1:0] NIN_TWO   = 2'd2;
  localparam logic [1:0] NIN_THREE = 2'd3;

  localparam logic [1:0] PIECES_ONE = 2'd1;
  localparam logic [1:0] PIECES_TWO = 2'd2;

  // Vertices carried past the divider: first inside, second inside, third input.
  typedef struct packed {
    vtx_t       s0;
    vtx_t       s1;
    vtx_t       s2;
    logic [1:0] nin;
  } side_t;

endpackage

>>> sv/triangle_plane_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// Clips one triangle against a plane (point + inward normal) and streams out
// zero, one or two triangles per input word.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  in_*      | slave     | tdata: a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
//  out_*     | master    | tdata: nine output coords; tuser: piece_total;
//            |           | tlast: is_last
//  cfg_*     | write     | cfg_idx 0..5 = px,py,pz,nx,ny,nz; other indices drop
//
//  Stages: 3 distance, 1 pair select, FRAC_BITS divider steps, 2 interpolation
//  and 1 output register.
//  One word enters per cycle while in_tready is high; an input that yields two
//  triangles holds the output register, and the input, for its second triangle.
//  The whole pipeline advances together; a stall on out_tready freezes all
//  stages and drops nothing. Inputs with no inside vertex vanish at pair select.
//  Reset (synchronous, rst_n low) clears valid bits and loads the default plane.
// ----------------------------------------------------------------------------
module triangle_plane_clipper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [9*tpc_pkg::COORD_W-1:0]    in_tdata,   // a_x,a_y,a_z,b_x..c_z from bit 0
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [9*tpc_pkg::COORD_W-1:0]    out_tdata,  // out_a_x .. out_c_z from bit 0
  output logic [1:0]                       out_tuser,  // piece_total
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tpc_pkg::COORD_W-1:0]      cfg_wdata
);

  localparam int F = tpc_pkg::FRAC_BITS;

  typedef struct packed {
    tpc_pkg::side_t side;
    tpc_pkg::vtx_t  vi0;
    tpc_pkg::vtx_t  vi1;
    tpc_pkg::dvec_t dl0;
    tpc_pkg::dvec_t dl1;
  } mid_t;

  // plane registers
  tpc_pkg::vtx_t pt_r;
  tpc_pkg::vtx_t nrm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r  <= '0;
      nrm_r <= {tpc_pkg::COORD_W'(32'h0001_0000), {(2*tpc_pkg::COORD_W){1'b0}}};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tpc_pkg::CFG_PX: pt_r[0]  <= cfg_wdata;
        tpc_pkg::CFG_PY: pt_r[1]  <= cfg_wdata;
        tpc_pkg::CFG_PZ: pt_r[2]  <= cfg_wdata;
        tpc_pkg::CFG_NX: nrm_r[0] <= cfg_wdata;
        tpc_pkg::CFG_NY: nrm_r[1] <= cfg_wdata;
        tpc_pkg::CFG_NZ: nrm_r[2] <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // global advance: the output register is empty or hands off its last word
  logic adv;
  logic out_v_r;
  assign adv       = !out_v_r || (out_tready && out_tlast);
  assign in_tready = adv;

  // distance stages
  tpc_pkg::vtx_t  in_tri [3];
  tpc_pkg::vtx_t  d_tri  [3];
  tpc_pkg::dist_t d_dist [3];
  logic           d_v;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      in_tri[j] = in_tdata[j*3*tpc_pkg::COORD_W +: 3*tpc_pkg::COORD_W];
    end
  end

  tpc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (in_tvalid),
    .in_tri  (in_tri),
    .pt      (pt_r),
    .nrm     (nrm_r),
    .out_v   (d_v),
    .out_tri (d_tri),
    .out_d   (d_dist)
  );

  // pair select: find inside / outside vertices in input order
  logic [2:0]                ins;
  logic [1:0]                nin;
  logic [1:0]                ia, ib, oa, ob, p1i;
  logic [tpc_pkg::DEN_W-1:0] num0_nxt, num1_nxt, den0_nxt, den1_nxt;
  mid_t                      mid_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ins[j] = ~d_dist[j][tpc_pkg::DIST_W-1];
    end
    nin = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
    ia  = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
    ib  = (ins[0] && ins[1]) ? 2'd1 : 2'd2;
    oa  = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
    ob  = (!ins[0] && !ins[1]) ? 2'd1 : 2'd2;
    // one inside: (a,o0),(a,o1); two inside: (a,o0),(b,o0)
    p1i = (nin == tpc_pkg::NIN_TWO) ? ib : ia;

    num0_nxt = tpc_pkg::DEN_W'(d_dist[ia]);
    num1_nxt = tpc_pkg::DEN_W'(d_dist[p1i]);
    den0_nxt = tpc_pkg::DEN_W'($signed(d_dist[ia]) - $signed(d_dist[oa]));
    den1_nxt = (nin == tpc_pkg::NIN_TWO)
             ? tpc_pkg::DEN_W'($signed(d_dist[ib]) - $signed(d_dist[oa]))
             : tpc_pkg::DEN_W'($signed(d_dist[ia]) - $signed(d_dist[ob]));

    mid_nxt.side.s0  = d_tri[ia];
    mid_nxt.side.s1  = d_tri[ib];
    mid_nxt.side.s2  = d_tri[2];
    mid_nxt.side.nin = nin;
    mid_nxt.vi0      = d_tri[ia];
    mid_nxt.vi1      = d_tri[p1i];
    for (int k = 0; k < 3; k++) begin
      mid_nxt.dl0[k] = $signed({d_tri[oa][k][tpc_pkg::COORD_W-1], d_tri[oa][k]})
                     - $signed({d_tri[ia][k][tpc_pkg::COORD_W-1], d_tri[ia][k]});
      mid_nxt.dl1[k] = (nin == tpc_pkg::NIN_TWO)
        ? $signed({d_tri[oa][k][tpc_pkg::COORD_W-1], d_tri[oa][k]})
          - $signed({d_tri[ib][k][tpc_pkg::COORD_W-1], d_tri[ib][k]})
        : $signed({d_tri[ob][k][tpc_pkg::COORD_W-1], d_tri[ob][k]})
          - $signed({d_tri[ia][k][tpc_pkg::COORD_W-1], d_tri[ia][k]});
    end
  end

  logic [tpc_pkg::DEN_W-1:0] num0_r, num1_r, den0_r, den1_r;
  mid_t                      sel_r;
  logic                      sel_v_r;

  // side line runs beside the divider, then beside the interpolators
  mid_t                      mid_r  [F];
  logic [F-1:0]              midv_r;
  tpc_pkg::side_t            tail_r [2];
  logic [1:0]                tailv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
      midv_r  <= '0;
      tailv_r <= '0;
    end else if (adv) begin
      // drop triangles that lie wholly outside
      sel_v_r <= d_v && (nin != tpc_pkg::NIN_NONE);
      midv_r  <= {midv_r[F-2:0], sel_v_r};
      tailv_r <= {tailv_r[0], midv_r[F-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num0_r <= num0_nxt;
      num1_r <= num1_nxt;
      den0_r <= den0_nxt;
      den1_r <= den1_nxt;
      sel_r  <= mid_nxt;
      mid_r[0] <= sel_r;
      for (int s = 1; s < F; s++) begin
        mid_r[s] <= mid_r[s-1];
      end
      tail_r[0] <= mid_r[F-1].side;
      tail_r[1] <= tail_r[0];
    end
  end

  // intersection parameters
  logic [F-1:0] t0, t1;

  tpc_div u_div0 (.clk(clk), .adv(adv), .num(num0_r), .den(den0_r), .quo(t0));
  tpc_div u_div1 (.clk(clk), .adv(adv), .num(num1_r), .den(den1_r), .quo(t1));

  tpc_pkg::vtx_t x0, x1;

  tpc_lerp u_lerp0 (
    .clk (clk), .adv (adv), .vi (mid_r[F-1].vi0), .dl (mid_r[F-1].dl0), .t (t0), .xo (x0)
  );
  tpc_lerp u_lerp1 (
    .clk (clk), .adv (adv), .vi (mid_r[F-1].vi1), .dl (mid_r[F-1].dl1), .t (t1), .xo (x1)
  );

  // output register: holds one clipped input, emits one or two words
  tpc_pkg::side_t side_r;
  tpc_pkg::vtx_t  x0_r, x1_r;
  logic           phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= tailv_r[1];
      phase_r <= 1'b0;
    end else if (out_tready) begin
      // first of two triangles taken: advance to the second
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= tail_r[1];
      x0_r   <= x0;
      x1_r   <= x1;
    end
  end

  tpc_pkg::vtx_t oa_v, ob_v, oc_v;

  always_comb begin
    if (phase_r) begin
      oa_v      = side_r.s1;
      ob_v      = x0_r;
      oc_v      = x1_r;
      out_tuser = tpc_pkg::PIECES_TWO;
      out_tlast = 1'b1;
    end else begin
      oa_v      = side_r.s0;
      ob_v      = (side_r.nin == tpc_pkg::NIN_ONE) ? x0_r : side_r.s1;
      oc_v      = (side_r.nin == tpc_pkg::NIN_THREE) ? side_r.s2 :
                  (side_r.nin == tpc_pkg::NIN_ONE) ? x1_r : x0_r;
      out_tuser = (side_r.nin == tpc_pkg::NIN_TWO) ? tpc_pkg::PIECES_TWO
                                                   : tpc_pkg::PIECES_ONE;
      out_tlast = (side_r.nin != tpc_pkg::NIN_TWO);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {oc_v, ob_v, oa_v};

  // a single-piece word always closes its input
  a_one_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tpc_pkg::PIECES_ONE |-> out_tlast)
    else $error("single piece without last flag");

  // the first of two pieces is followed by the second at once
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tlast && out_tuser == tpc_pkg::PIECES_TWO)
    else $error("second piece missing");

  // piece count is one or two on every word
  a_piece_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == tpc_pkg::PIECES_ONE || out_tuser == tpc_pkg::PIECES_TWO))
    else $error("bad piece count");

  // a stall holds the whole pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sel_v_r) && $stable(midv_r) && $stable(tailv_r))
    else $error("pipeline moved during stall");

endmodule

>>> sv/tpc_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_dist
// Three-stage signed plane distance of each vertex: subtract, multiply, sum.
// ----------------------------------------------------------------------------
module tpc_dist (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  tpc_pkg::vtx_t        in_tri [3],
  input  tpc_pkg::vtx_t        pt,
  input  tpc_pkg::vtx_t        nrm,
  output logic                 out_v,
  output tpc_pkg::vtx_t        out_tri [3],
  output tpc_pkg::dist_t       out_d [3]
);

  logic signed [tpc_pkg::DIFF_W-1:0] diff_r [3][3];
  logic signed [tpc_pkg::DIFF_W-1:0] diff_nxt [3][3];
  logic signed [tpc_pkg::PROD_W-1:0] prod_r [3][3];
  logic signed [tpc_pkg::PROD_W-1:0] prod_nxt [3][3];
  tpc_pkg::dist_t                    d_r [3];
  tpc_pkg::dist_t                    d_nxt [3];
  tpc_pkg::vtx_t                     tri1_r [3];
  tpc_pkg::vtx_t                     tri2_r [3];
  tpc_pkg::vtx_t                     tri3_r [3];
  logic [2:0]                        v_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        diff_nxt[j][k] = $signed({in_tri[j][k][tpc_pkg::COORD_W-1], in_tri[j][k]})
                       - $signed({pt[k][tpc_pkg::COORD_W-1], pt[k]});
        prod_nxt[j][k] = diff_r[j][k] * $signed(nrm[k]);
      end
      d_nxt[j] = prod_r[j][0] + prod_r[j][1] + prod_r[j][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r <= diff_nxt;
      prod_r <= prod_nxt;
      d_r    <= d_nxt;
      tri1_r <= in_tri;
      tri2_r <= tri1_r;
      tri3_r <= tri2_r;
    end
  end

  assign out_v   = v_r[2];
  assign out_tri = tri3_r;
  assign out_d   = d_r;

endmodule

>>> sv/tpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_div
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS stages.
// Numerator must be below the denominator; the result is num*2^F/den.
// ----------------------------------------------------------------------------
module tpc_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [tpc_pkg::DEN_W-1:0]     num,
  input  logic [tpc_pkg::DEN_W-1:0]     den,
  output logic [tpc_pkg::FRAC_BITS-1:0] quo
);

  localparam int F = tpc_pkg::FRAC_BITS;

  logic [tpc_pkg::DEN_W-1:0] rem_r   [F];
  logic [tpc_pkg::DEN_W-1:0] den_r   [F];
  logic [F-1:0]              q_r     [F];
  logic [tpc_pkg::DEN_W-1:0] rem_nxt [F];
  logic [F-1:0]              q_nxt   [F];

  always_comb begin
    logic [tpc_pkg::DEN_W:0]   r2;
    logic [tpc_pkg::DEN_W-1:0] rp;
    logic [tpc_pkg::DEN_W-1:0] dp;
    logic [F-1:0]              qp;
    logic                      ge;
    for (int s = 0; s < F; s++) begin
      rp = (s == 0) ? num : rem_r[(s == 0) ? 0 : s - 1];
      dp = (s == 0) ? den : den_r[(s == 0) ? 0 : s - 1];
      qp = (s == 0) ? '0  : q_r[(s == 0) ? 0 : s - 1];
      r2 = {rp, 1'b0};
      ge = (r2 >= {1'b0, dp});
      rem_nxt[s] = ge ? tpc_pkg::DEN_W'(r2 - {1'b0, dp}) : tpc_pkg::DEN_W'(r2);
      q_nxt[s]   = {qp[F-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < F; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        den_r[s] <= (s == 0) ? den : den_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign quo = q_r[F-1];

endmodule

>>> sv/tpc_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_lerp
// Edge point: vi + floor(delta*t / 2^F), saturated. Multiply, then add.
// ----------------------------------------------------------------------------
module tpc_lerp (
  input  logic                          clk,
  input  logic                          adv,
  input  tpc_pkg::vtx_t                 vi,
  input  tpc_pkg::dvec_t                dl,
  input  logic [tpc_pkg::FRAC_BITS-1:0] t,
  output tpc_pkg::vtx_t                 xo
);

  logic signed [tpc_pkg::MUL_W-1:0] prod_r   [3];
  logic signed [tpc_pkg::MUL_W-1:0] prod_nxt [3];
  tpc_pkg::vtx_t                    vi_r;
  tpc_pkg::vtx_t                    x_r;
  tpc_pkg::vtx_t                    x_nxt;

  always_comb begin
    logic signed [tpc_pkg::MUL_W-1:0] sh;
    logic signed [tpc_pkg::SUM_W-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = $signed(dl[k]) * $signed({1'b0, t});
      // arithmetic shift is the floor for both signs
      sh  = prod_r[k] >>> tpc_pkg::FRAC_BITS;
      sum = $signed({{(tpc_pkg::SUM_W - tpc_pkg::COORD_W){vi_r[k][tpc_pkg::COORD_W-1]}},
                     vi_r[k]}) + $signed(sh[tpc_pkg::SUM_W-1:0]);
      if (&sum[tpc_pkg::SUM_W-1:tpc_pkg::COORD_W-1] ||
          ~|sum[tpc_pkg::SUM_W-1:tpc_pkg::COORD_W-1]) begin
        x_nxt[k] = sum[tpc_pkg::COORD_W-1:0];
      end else if (sum[tpc_pkg::SUM_W-1]) begin
        x_nxt[k] = {1'b1, {(tpc_pkg::COORD_W-1){1'b0}}};
      end else begin
        x_nxt[k] = {1'b0, {(tpc_pkg::COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      vi_r   <= vi;
      x_r    <= x_nxt;
    end
  end

  assign xo = x_r;

endmodule
